// File: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and field widths of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int REQ_W    = 14;
	localparam int HANDLE_W = 10;
	localparam int ADDR_W   = 10;
	localparam int LFREE_W  = 14;
	localparam int POOL_W   = 14;
	localparam int POOL_RST = 8192;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic               ok;
		logic [ADDR_W-1:0]  block_addr;
		logic [LFREE_W-1:0] largest_free;
	} ffba_res_t;

endpackage

// File: design/ffba_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffba_hdr_mem
// Header word store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ffba_hdr_mem #(
	parameter int DEPTH = 1024,
	parameter int DW    = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [DW-1:0]            rdata0,
	output logic [DW-1:0]            rdata1
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: design/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Header walker: format, coalesce, first-fit allocate, free, largest scan.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; #(
	parameter int POOL_WORDS   = 1024,
	parameter int WORD_BYTES   = 8,
	parameter int HEADER_WORDS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POOL_W-1:0]   cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [REQ_W-1:0]    in_bytes,
	input  logic [HANDLE_W-1:0] in_handle,
	output logic                res_valid,
	input  logic                res_ready,
	output ffba_res_t           res
);

	localparam int AW  = $clog2(POOL_WORDS);
	localparam int BW  = $clog2(POOL_WORDS * WORD_BYTES);
	localparam int PW  = AW + 2;
	localparam int SH  = $clog2(WORD_BYTES);
	localparam int HB  = HEADER_WORDS * WORD_BYTES;
	localparam int CW  = ((BW > REQ_W) ? BW : REQ_W) + 2;
	localparam int CAP = POOL_WORDS * WORD_BYTES;
	localparam int LO  = 2 * HB + WORD_BYTES;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FMT0 = 4'd1;
	localparam logic [3:0] ST_FMT1 = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_HD   = 4'd4;
	localparam logic [3:0] ST_CN   = 4'd5;
	localparam logic [3:0] ST_WR   = 4'd6;
	localparam logic [3:0] ST_DONE = 4'd7;

	localparam logic [2:0] PH_C1    = 3'd0;
	localparam logic [2:0] PH_ALLOC = 3'd1;
	localparam logic [2:0] PH_FREE  = 3'd2;
	localparam logic [2:0] PH_C2    = 3'd3;
	localparam logic [2:0] PH_LG    = 3'd4;

	logic [3:0]          state_q;
	logic [2:0]          ph_q;
	logic [2:0]          ph_nx;
	logic                fmt_pend_q;
	logic [POOL_W-1:0]   pool_q;
	logic [PW-1:0]       end_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       nxt_q;
	logic [BW-1:0]       a_q, f_q;
	logic [CW-1:0]       b_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                ok_q;
	logic [AW-1:0]       addr_q;
	logic [BW-1:0]       best_q;
	logic [AW-1:0]       wa_q [4];
	logic [BW-1:0]       wd_q [4];
	logic [1:0]          wn_q, wi_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [BW-1:0]       wdata, rd0, rd1;
	logic [31:0]         pm, pc;
	logic [PW-1:0]       fmt_end;
	logic [BW-1:0]       fmt_free;
	logic [PW-1:0]       nxt, moved, rpos;
	logic [CW-1:0]       a_w, f_w, rq;
	logic                exit_c;

	ffba_hdr_mem #(.DEPTH(POOL_WORDS), .DW(BW)) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr),
		.raddr1 (raddr + AW'(1)),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	always_comb begin
		pm = {{(32-POOL_W){1'b0}}, pool_q} & ~32'(WORD_BYTES - 1);
		pc = (pm > 32'(CAP)) ? 32'(CAP) : pm;
		if (pc < 32'(LO)) begin
			pc = 32'(LO);
		end
		fmt_end  = PW'((pc - 32'(HB)) >> SH);
		fmt_free = BW'(pc - 32'(2 * HB));
	end

	always_comb begin
		a_w   = CW'(rd0);
		f_w   = CW'(rd1);
		nxt   = pos_q + PW'(HEADER_WORDS) + PW'((a_w + f_w) >> SH);
		moved = pos_q + PW'(HEADER_WORDS) + PW'(a_q >> SH);
		rpos  = pos_q + PW'(HEADER_WORDS) + PW'(b_q >> SH);
		rq    = CW'(in_bytes) + CW'(WORD_BYTES - 1);
		raddr = (state_q == ST_HD) ? nxt[AW-1:0] : pos_q[AW-1:0];
		exit_c = (pos_q >= end_q) || ((ph_q == PH_ALLOC) && (b_q == '0));
		case (ph_q)
			PH_C1:   ph_nx = PH_ALLOC;
			PH_LG:   ph_nx = PH_LG;
			default: ph_nx = (ph_q == PH_C2) ? PH_LG : PH_C2;
		endcase
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			ST_FMT0: begin
				we = 1'b1;
			end
			ST_FMT1: begin
				we    = 1'b1;
				waddr = AW'(1);
				wdata = fmt_free;
			end
			ST_WR: begin
				we    = 1'b1;
				waddr = wa_q[wi_q];
				wdata = wd_q[wi_q];
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !fmt_pend_q;
	assign res_valid = (state_q == ST_DONE);
	assign res.ok           = ok_q;
	assign res.block_addr   = ok_q ? ADDR_W'(addr_q) : '0;
	assign res.largest_free = LFREE_W'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= PH_C1;
			fmt_pend_q <= 1'b1;
			pool_q     <= POOL_W'(POOL_RST);
			end_q      <= '0;
			pos_q      <= '0;
			wn_q       <= '0;
			wi_q       <= '0;
			ok_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q     <= cfg_wdata;
				fmt_pend_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (fmt_pend_q) begin
						state_q <= ST_FMT0;
					end else if (in_valid) begin
						b_q      <= rq & ~CW'(WORD_BYTES - 1);
						handle_q <= in_handle;
						ok_q     <= 1'b0;
						addr_q   <= '0;
						pos_q    <= '0;
						ph_q     <= (in_op == OP_FREE) ? PH_FREE : PH_C1;
						state_q  <= ST_RD;
					end
				end
				ST_FMT0: state_q <= ST_FMT1;
				ST_FMT1: begin
					end_q <= fmt_end;
					if (!cfg_we) begin
						fmt_pend_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					if (exit_c) begin
						ph_q  <= ph_nx;
						pos_q <= '0;
						if (ph_q != PH_LG) begin
							best_q <= '0;
						end
						state_q <= (ph_q == PH_LG) ? ST_DONE : ST_RD;
					end else begin
						state_q <= ST_HD;
					end
				end
				ST_HD: begin
					a_q   <= rd0;
					f_q   <= rd1;
					nxt_q <= nxt;
					case (ph_q)
						PH_ALLOC: begin
							if (rd0 == '0 && f_w >= b_q) begin
								ok_q     <= 1'b1;
								addr_q   <= pos_q[AW-1:0] + AW'(HEADER_WORDS);
								wa_q[0]  <= pos_q[AW-1:0];
								wd_q[0]  <= BW'(b_q);
								wa_q[1]  <= pos_q[AW-1:0] + AW'(1);
								if (f_w >= b_q + CW'(HB + WORD_BYTES)) begin
									wd_q[1] <= '0;
									wa_q[2] <= rpos[AW-1:0];
									wd_q[2] <= '0;
									wa_q[3] <= rpos[AW-1:0] + AW'(1);
									wd_q[3] <= BW'(f_w - b_q - CW'(HB));
									wn_q    <= 2'd3;
								end else begin
									wd_q[1] <= BW'(f_w - b_q);
									wn_q    <= 2'd1;
								end
								pos_q   <= '0;
								ph_q    <= PH_C2;
								wi_q    <= '0;
								state_q <= ST_WR;
							end else begin
								pos_q   <= nxt;
								state_q <= ST_RD;
							end
						end
						PH_FREE: begin
							if ((32'(pos_q) + 32'(HEADER_WORDS) == 32'(handle_q))
									&& rd0 != '0) begin
								ok_q    <= 1'b1;
								wa_q[0] <= pos_q[AW-1:0] + AW'(1);
								wd_q[0] <= BW'(a_w + f_w);
								wa_q[1] <= pos_q[AW-1:0];
								wd_q[1] <= '0;
								wn_q    <= 2'd1;
								wi_q    <= '0;
								pos_q   <= '0;
								ph_q    <= PH_C2;
								state_q <= ST_WR;
							end else begin
								pos_q   <= nxt;
								state_q <= ST_RD;
							end
						end
						PH_LG: begin
							if (rd0 == '0 && rd1 > best_q) begin
								best_q <= rd1;
							end
							pos_q   <= nxt;
							state_q <= ST_RD;
						end
						default: begin
							if (nxt >= end_q) begin
								ph_q    <= ph_nx;
								pos_q   <= '0;
								best_q  <= '0;
								state_q <= ST_RD;
							end else begin
								state_q <= ST_CN;
							end
						end
					endcase
				end
				ST_CN: begin
					if (a_q == '0 && rd0 == '0 && rd1 != '0) begin
						wa_q[0] <= pos_q[AW-1:0] + AW'(1);
						wd_q[0] <= BW'(CW'(f_q) + CW'(rd1) + CW'(HB));
						wn_q    <= 2'd0;
						wi_q    <= '0;
						state_q <= ST_WR;
					end else if (f_q != '0 && rd0 == '0 && rd1 != '0) begin
						wa_q[0] <= pos_q[AW-1:0] + AW'(1);
						wd_q[0] <= '0;
						wa_q[1] <= moved[AW-1:0];
						wd_q[1] <= '0;
						wa_q[2] <= moved[AW-1:0] + AW'(1);
						wd_q[2] <= BW'(CW'(f_q) + CW'(rd1));
						wn_q    <= 2'd2;
						wi_q    <= '0;
						pos_q   <= moved;
						state_q <= ST_WR;
					end else begin
						pos_q   <= nxt_q;
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					wi_q <= wi_q + 2'd1;
					if (wi_q == wn_q) begin
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we)
		else $error("header write while idle");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result changed while stalled");

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RD))
		else $error("accepted item did not start walk");

	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (wi_q <= wn_q))
		else $error("write queue overrun");

endmodule

// File: design/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a pool of block headers held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser = op (0 allocate, 1 free), tdata holds
//   alloc_bytes and block_handle. m_axis returns one result per request:
//   tuser = ok, tdata holds block_addr and largest_free.
//   cfg_we/cfg_wdata write pool_bytes and reformat the pool as one free block.
//   Each request walks the header chain: an allocate runs a coalescing pass,
//   the first-fit search, a second coalescing pass and a largest-block scan;
//   a free runs the handle search, a coalescing pass and the scan. A search
//   or scan visit reads a header and then decides; a coalescing visit also
//   reads the neighbor header, and each header word is written in turn.
//   One request is processed at a time.
//   After reset (and after each cfg write) the pool is formatted, and
//   s_axis_tready rises once formatting is done. A finished result sits in the
//   output register; the next request is taken while it waits, and a stalled
//   receiver holds the walker only when a second result is ready.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; #(
	parameter int POOL_WORDS   = 1024,
	parameter int WORD_BYTES   = 8,
	parameter int HEADER_WORDS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POOL_W-1:0]   cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // alloc_bytes[13:0], block_handle[23:14]
	input  logic                s_axis_tuser,  // op
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // block_addr[9:0], largest_free[23:10]
	output logic                m_axis_tuser   // ok
);

	ffba_res_t res, res_q;
	logic      res_valid, res_ready, mv_q;

	ffba_ctrl #(
		.POOL_WORDS   (POOL_WORDS),
		.WORD_BYTES   (WORD_BYTES),
		.HEADER_WORDS (HEADER_WORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_bytes  (s_axis_tdata[13:0]),
		.in_handle (s_axis_tdata[23:14]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !mv_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (res_ready) begin
			mv_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tuser  = res_q.ok;
	assign m_axis_tdata  = {res_q.largest_free, res_q.block_addr};

endmodule
